// ===== hw/rtl/cross_stencil_threshold_detector_defines.svh =====
// Assertion macros shared by the detector's RTL files.
// Each use names a label, a trigger expression and an expected expression.
// The checks are compiled out when SYNTH is defined.
`ifndef CROSS_STENCIL_THRESHOLD_DETECTOR_DEFINES_SVH
`define CROSS_STENCIL_THRESHOLD_DETECTOR_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication
`define CSD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csd check failed");

// Next-cycle implication
`define CSD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csd check failed");

`else

`define CSD_ASSERT_IMPL(name, ante, cons)

`define CSD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== hw/rtl/csd_pkg.sv =====
`default_nettype none

package csd_pkg;

  // Image size limits
  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;

  // Fixed field widths
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int IDX_W     = 10;
  localparam int SUM_W     = PIX_W + 3;

  // Derived counter widths
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int COLS_W = $clog2(MAX_COLS + 1);

  // Register defaults
  localparam logic [CFG_W-1:0] RST_NUM_ROWS      = CFG_W'(1024);
  localparam logic [CFG_W-1:0] RST_NUM_COLS      = CFG_W'(1024);
  localparam logic [CFG_W-1:0] RST_SUM_THRESHOLD = CFG_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS      = 2'd0,
    REG_NUM_COLS      = 2'd1,
    REG_SUM_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // Position and edge flags of one pixel word
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             flush_row;
    logic             row_end;
    logic             right_ok;
    logic             above_ok;
    logic             produce;
  } scan_info_t;

  // Line buffer write-back
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_wr_t;

  // Line buffer read data
  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] right;
  } line_rd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csd_scan.sv =====
`default_nettype none
`include "cross_stencil_threshold_detector_defines.svh"

module csd_scan (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            accept,
  input  wire logic                            command,
  input  wire logic [csd_pkg::PIX_W-1:0]       pixel,
  input  wire logic [csd_pkg::CFG_W-1:0]       num_rows,
  input  wire logic [csd_pkg::CFG_W-1:0]       num_cols,
  output csd_pkg::scan_info_t                  info,
  output logic [csd_pkg::PIX_W-1:0]            below,
  output logic [csd_pkg::COL_W-1:0]            right_addr
);

  logic [csd_pkg::ROW_W-1:0]  row_count;
  logic [csd_pkg::COL_W-1:0]  col_count;
  logic [csd_pkg::ROW_W-1:0]  rows;
  logic [csd_pkg::COLS_W-1:0] cols;

  // Clamp the size registers to the supported range
  always_comb begin
    if (num_rows == '0) begin
      rows = csd_pkg::ROW_W'(1);
    end else if (32'(num_rows) > csd_pkg::MAX_ROWS) begin
      rows = csd_pkg::ROW_W'(csd_pkg::MAX_ROWS);
    end else begin
      rows = csd_pkg::ROW_W'(num_rows);
    end
    if (num_cols == '0) begin
      cols = csd_pkg::COLS_W'(1);
    end else if (32'(num_cols) > csd_pkg::MAX_COLS) begin
      cols = csd_pkg::COLS_W'(csd_pkg::MAX_COLS);
    end else begin
      cols = csd_pkg::COLS_W'(num_cols);
    end
  end

  // Classify the current scan position
  always_comb begin
    info.row       = row_count;
    info.col       = col_count;
    info.flush_row = 32'(row_count) >= 32'(rows);
    info.row_end   = (32'(col_count) + 32'd1) >= 32'(cols);
    info.right_ok  = !info.row_end && ((32'(col_count) + 32'd1) < csd_pkg::MAX_COLS);
    info.above_ok  = row_count >= csd_pkg::ROW_W'(2);
    info.produce   = row_count != '0;
    right_addr     = col_count + csd_pkg::COL_W'(1);
    below          = (command == csd_pkg::CMD_FLUSH || info.flush_row) ? '0 : pixel;
  end

  // Advance raster position on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (info.row_end) begin
        col_count <= '0;
        row_count <= info.flush_row ? '0 : row_count + csd_pkg::ROW_W'(1);
      end else begin
        col_count <= col_count + csd_pkg::COL_W'(1);
      end
    end
  end

  `CSD_ASSERT_NEXT(a_row_wrap, accept && info.row_end, col_count == '0)
  `CSD_ASSERT_NEXT(a_image_wrap, accept && info.row_end && info.flush_row, row_count == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/csd_line_buf.sv =====
`default_nettype none

module csd_line_buf (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [csd_pkg::COL_W-1:0]   rd_col,
  input  wire logic [csd_pkg::COL_W-1:0]   rd_right,
  input  wire csd_pkg::line_wr_t           wr,
  output csd_pkg::line_rd_t                rd
);

  logic [csd_pkg::PIX_W-1:0] upper_mem  [csd_pkg::MAX_COLS];
  logic [csd_pkg::PIX_W-1:0] middle_mem [csd_pkg::MAX_COLS];
  logic                      hit_col;
  logic                      hit_right;

  // Detect a write-back landing on an address read in the same cycle
  assign hit_col   = wr.en && (wr.addr == rd_col);
  assign hit_right = wr.en && (wr.addr == rd_right);

  // Write back both lines
  always_ff @(posedge clk) begin
    if (wr.en) begin
      upper_mem[wr.addr]  <= wr.upper;
      middle_mem[wr.addr] <= wr.middle;
    end
  end

  // Read with forwarding of the concurrent write-back
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.center <= hit_col ? wr.middle : middle_mem[rd_col];
      rd.above  <= hit_col ? wr.upper : upper_mem[rd_col];
      rd.right  <= hit_right ? wr.middle : middle_mem[rd_right];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csd_eval.sv =====
`default_nettype none
`include "cross_stencil_threshold_detector_defines.svh"

module csd_eval (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire csd_pkg::scan_info_t           info_in,
  input  wire logic [csd_pkg::PIX_W-1:0]     below_in,
  input  wire csd_pkg::line_rd_t             rd,
  input  wire logic [csd_pkg::CFG_W-1:0]     sum_threshold,
  output csd_pkg::line_wr_t                  wr,
  output logic                               hold,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic                               is_star,
  output logic [csd_pkg::IDX_W-1:0]          row_index,
  output logic [csd_pkg::IDX_W-1:0]          col_index,
  output logic                               last_of_image
);

  logic                      s1_valid;
  csd_pkg::scan_info_t       s1_info;
  logic [csd_pkg::PIX_W-1:0] s1_below;
  logic [csd_pkg::PIX_W-1:0] left_pix;
  logic                      s1_adv;
  logic [csd_pkg::PIX_W-1:0] above;
  logic [csd_pkg::PIX_W-1:0] left;
  logic [csd_pkg::PIX_W-1:0] right;
  logic [csd_pkg::SUM_W-1:0] sum;

  // Advance when the output register is free or being drained
  assign s1_adv = s1_valid && (!res_valid || !res_stall);
  assign hold   = s1_valid && !s1_adv;

  // Mask neighbors outside the image and add the cross
  always_comb begin
    above = s1_info.above_ok ? rd.above : '0;
    left  = (s1_info.col == '0) ? '0 : left_pix;
    right = s1_info.right_ok ? rd.right : '0;
    sum   = csd_pkg::SUM_W'(s1_below) + csd_pkg::SUM_W'(rd.center)
          + csd_pkg::SUM_W'(above) + csd_pkg::SUM_W'(left) + csd_pkg::SUM_W'(right);
  end

  // Shift the lines down by one row at this column
  always_comb begin
    wr.en     = s1_adv;
    wr.addr   = s1_info.col;
    wr.upper  = rd.center;
    wr.middle = s1_below;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      left_pix  <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        left_pix <= rd.center;
      end
      if (s1_adv && s1_info.produce) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info  <= info_in;
      s1_below <= below_in;
    end
    if (s1_adv && s1_info.produce) begin
      is_star       <= 32'(sum) > 32'(sum_threshold);
      row_index     <= csd_pkg::IDX_W'(s1_info.row - csd_pkg::ROW_W'(1));
      col_index     <= csd_pkg::IDX_W'(s1_info.col);
      last_of_image <= s1_info.flush_row && s1_info.row_end;
    end
  end

  `CSD_ASSERT_NEXT(a_s1_held, hold, s1_valid && s1_info == $past(s1_info))

endmodule

`default_nettype wire

// ===== hw/rtl/cross_stencil_threshold_detector.sv =====
// Five-point cross stencil star detector, one pixel word per clock unless stalled.
// Result for pixel (r, c) is registered once the word of (r+1, c) has passed the
// synchronous line buffer read and the s1 stage; the row of delay comes from the
// two line buffers. Sustained rate is one word per cycle while res_stall is low.
// Reset (synchronous) restores register defaults and zeroes the raster counters;
// line buffers are not cleared; their contents reach a result only after being written.
`default_nettype none
`include "cross_stencil_threshold_detector_defines.svh"

module cross_stencil_threshold_detector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pix_valid,
  output logic                                   pix_stall,
  input  wire logic                              command,
  input  wire logic [csd_pkg::PIX_W-1:0]         pixel,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output logic                                   is_star,
  output logic [csd_pkg::IDX_W-1:0]              row_index,
  output logic [csd_pkg::IDX_W-1:0]              col_index,
  output logic                                   last_of_image,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [csd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [csd_pkg::CFG_W-1:0]         cfg_data
);

  logic [csd_pkg::CFG_W-1:0] num_rows;
  logic [csd_pkg::CFG_W-1:0] num_cols;
  logic [csd_pkg::CFG_W-1:0] sum_threshold;
  logic                      pix_accept;
  logic                      hold;
  csd_pkg::scan_info_t       info;
  logic [csd_pkg::PIX_W-1:0] below;
  logic [csd_pkg::COL_W-1:0] right_addr;
  csd_pkg::line_wr_t         wr;
  csd_pkg::line_rd_t         rd;

  assign cfg_ready  = 1'b1;
  assign pix_stall  = hold;
  assign pix_accept = pix_valid && !pix_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows      <= csd_pkg::RST_NUM_ROWS;
      num_cols      <= csd_pkg::RST_NUM_COLS;
      sum_threshold <= csd_pkg::RST_SUM_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csd_pkg::REG_NUM_ROWS:      num_rows      <= cfg_data;
        csd_pkg::REG_NUM_COLS:      num_cols      <= cfg_data;
        csd_pkg::REG_SUM_THRESHOLD: sum_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  csd_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (pix_accept),
    .command    (command),
    .pixel      (pixel),
    .num_rows   (num_rows),
    .num_cols   (num_cols),
    .info       (info),
    .below      (below),
    .right_addr (right_addr)
  );

  csd_line_buf u_line_buf (
    .clk      (clk),
    .rd_en    (pix_accept),
    .rd_col   (info.col),
    .rd_right (right_addr),
    .wr       (wr),
    .rd       (rd)
  );

  csd_eval u_eval (
    .clk           (clk),
    .rst           (rst),
    .accept        (pix_accept),
    .info_in       (info),
    .below_in      (below),
    .rd            (rd),
    .sum_threshold (sum_threshold),
    .wr            (wr),
    .hold          (hold),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .is_star       (is_star),
    .row_index     (row_index),
    .col_index     (col_index),
    .last_of_image (last_of_image)
  );

  `CSD_ASSERT_NEXT(a_fwd_center, pix_accept && wr.en && wr.addr == info.col, rd.center == $past(wr.middle))

endmodule

`default_nettype wire
